FILE: rtl/cpc_pkg.sv
// Shared types, constants and the quarter-wave sine table of the Clarke/Park block.
package cpc_pkg;

	// Angle resolution and scaling
	localparam int unsigned ANGLE_STEPS = 1000;
	localparam int unsigned SCALE_SHIFT = 11;
	localparam int unsigned ANGLE_QTR   = ANGLE_STEPS / 4;
	localparam int unsigned ANGLE_HALF  = ANGLE_STEPS / 2;
	localparam int unsigned ANGLE_W     = 10;
	localparam int unsigned QTR_IDX_W   = $clog2(ANGLE_QTR + 1);

	localparam logic [ANGLE_W-1:0] STEPS_A = ANGLE_W'(ANGLE_STEPS);
	localparam logic [ANGLE_W-1:0] QTR_A   = ANGLE_W'(ANGLE_QTR);
	localparam logic [ANGLE_W-1:0] HALF_A  = ANGLE_W'(ANGLE_HALF);

	// 1/sqrt(3) in Q15
	localparam logic signed [15:0] INV_SQRT3_Q15 = 16'sd18919;

	// Reset value of the scale register
	localparam logic signed [15:0] SCALE_RESET = 16'sd2048;

	// Phase codes
	typedef enum logic [1:0] {
		PHASE_A    = 2'd0,
		PHASE_B    = 2'd1,
		PHASE_C    = 2'd2,
		PHASE_NONE = 2'd3
	} phase_t;

	// Register indexes
	typedef enum logic [1:0] {
		REG_CURRENT_SCALE = 2'd0,
		REG_ZERO_OFFSET_A = 2'd1,
		REG_ZERO_OFFSET_B = 2'd2,
		REG_ZERO_OFFSET_C = 2'd3
	} cfg_reg_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCALE,
		ST_REBUILD,
		ST_BETA,
		ST_D_FIRST,
		ST_D_SECOND,
		ST_Q_FIRST,
		ST_Q_SECOND
	} seq_state_t;

	// Quarter-wave table, entries 0..ANGLE_QTR
	typedef logic [14:0] sine_tbl_t [ANGLE_QTR+1];

	localparam logic [127:0] PI_Q60 = 128'h3243F6A8885A308D;
	localparam logic [127:0] PI_DIV = PI_Q60 / ANGLE_STEPS;
	localparam logic [127:0] PI_REM = PI_Q60 % ANGLE_STEPS;

	// Taylor term i divided by (2i)(2i+1), i in 1..20
	function automatic logic [63:0] series_div(input logic [63:0] t, input int i);
		logic [63:0] q;
		case (i)
			1:       q = t / 64'd6;
			2:       q = t / 64'd20;
			3:       q = t / 64'd42;
			4:       q = t / 64'd72;
			5:       q = t / 64'd110;
			6:       q = t / 64'd156;
			7:       q = t / 64'd210;
			8:       q = t / 64'd272;
			9:       q = t / 64'd342;
			10:      q = t / 64'd420;
			11:      q = t / 64'd506;
			12:      q = t / 64'd600;
			13:      q = t / 64'd702;
			14:      q = t / 64'd812;
			15:      q = t / 64'd930;
			16:      q = t / 64'd1056;
			17:      q = t / 64'd1190;
			18:      q = t / 64'd1332;
			19:      q = t / 64'd1482;
			default: q = t / 64'd1640;
		endcase
		return q;
	endfunction

	// round(32767*sin(2*pi*k/ANGLE_STEPS)) through a Q60 Taylor series
	function automatic logic [14:0] sine_mag(input int unsigned k);
		logic [127:0] x;
		logic [127:0] x2;
		logic [127:0] prod;
		logic [63:0]  term;
		logic [63:0]  sum;
		logic [63:0]  mag;
		logic [127:0] twok;
		x    = '0;
		twok = 128'(2 * k);
		x    = twok * PI_DIV + (twok * PI_REM) / ANGLE_STEPS;
		if (x > (PI_Q60 >> 1)) begin
			x = PI_Q60 - x;
		end
		x2   = (x * x) >> 60;
		term = x[63:0];
		sum  = x[63:0];
		for (int i = 1; i <= 20; i++) begin
			prod = {64'b0, term} * x2;
			term = series_div(64'(prod >> 60), i);
			if ((i % 2) == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		mag = (((sum >> 20) * 64'd32767) + (64'd1 << 39)) >> 40;
		return mag[14:0];
	endfunction

	function automatic sine_tbl_t build_sine_table();
		sine_tbl_t t;
		for (int unsigned k = 0; k <= ANGLE_QTR; k++) begin
			t[k] = sine_mag(k);
		end
		return t;
	endfunction

	localparam sine_tbl_t SINE_QUARTER = build_sine_table();

	// Full-wave sine from the quarter table, angle in 0..ANGLE_STEPS-1
	function automatic logic signed [15:0] sine_lookup(input logic [ANGLE_W-1:0] pos);
		logic [ANGLE_W-1:0] p;
		logic [ANGLE_W-1:0] q;
		logic               neg;
		logic signed [15:0] mag;
		neg = (pos > HALF_A);
		p   = neg ? (STEPS_A - pos) : pos;
		q   = (p > QTR_A) ? (HALF_A - p) : p;
		mag = signed'({1'b0, SINE_QUARTER[q[QTR_IDX_W-1:0]]});
		return neg ? -mag : mag;
	endfunction

	// Median of three samples
	function automatic logic signed [12:0] median3(
		input logic signed [12:0] a,
		input logic signed [12:0] b,
		input logic signed [12:0] c
	);
		logic signed [12:0] m;
		if (c > b) begin
			if (b > a) m = b;
			else       m = (c > a) ? a : c;
		end else if (c > a) begin
			m = c;
		end else begin
			m = (b > a) ? a : b;
		end
		return m;
	endfunction

endpackage

FILE: rtl/cpc_if.sv
// Valid/ready channels for phase items and transform results.
interface cpc_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         phase_index;
	logic signed [12:0] first_sample;
	logic signed [12:0] second_sample;
	logic signed [12:0] third_sample;
	logic [15:0]        duty_compare;
	logic [9:0]         rotor_angle;

	modport source (
		output valid, phase_index, first_sample, second_sample, third_sample,
		       duty_compare, rotor_angle,
		input  ready
	);
	modport sink (
		input  valid, phase_index, first_sample, second_sample, third_sample,
		       duty_compare, rotor_angle,
		output ready
	);
endinterface

interface cpc_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] current_a;
	logic signed [15:0] current_b;
	logic signed [15:0] current_c;
	logic signed [15:0] current_beta;
	logic signed [15:0] current_direct;
	logic signed [15:0] current_quadrature;

	modport source (
		output valid, current_a, current_b, current_c, current_beta,
		       current_direct, current_quadrature,
		input  ready
	);
	modport sink (
		input  valid, current_a, current_b, current_c, current_beta,
		       current_direct, current_quadrature,
		output ready
	);
endinterface

FILE: rtl/phase_current_clarke_park.sv
// Top level: phase current scaling, reconstruction, Clarke and Park transform.
//
// Items arrive one per phase (a, b, c). Each item's median sample is scaled and
// taken from that phase's zero offset; a and b items only update held values.
// A c item rebuilds the phase with the strictly largest duty (c if none), then
// runs Clarke and Park on one shared 18x16 multiplier under a small sequencer
// (scale, rebuild, beta, d products, q products): the result is then loaded
// into the output register, after which the input is ready again; sine and
// cosine are fetched from a quarter-wave table. The input is not ready while an
// item is in work; a finished result waits in its own output register, so the
// next item is taken while the result is still unread. A c item that finishes
// while the previous result is still unread waits in its last step until it is
// taken. Phase index 3 is consumed and gives no result. Registers are to be
// written only while the block is idle; the block itself does not enforce this.
module phase_current_clarke_park (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  cpc_pkg::cfg_reg_t   cfg_index,
	input  logic [15:0]         cfg_data,
	cpc_item_if.sink            phase_item,
	cpc_result_if.source        result
);
	import cpc_pkg::*;

	// Sequencer
	seq_state_t state_q, state_d;

	// Registers
	logic signed [15:0] scale_q;
	logic signed [15:0] offset_a_q, offset_b_q, offset_c_q;

	// Held phase values
	logic signed [15:0] held_ia_q, held_ib_q;
	logic [15:0]        held_da_q, held_db_q;

	// Item under work
	phase_t             phase_q;
	logic signed [12:0] med_q;
	logic [15:0]        duty_q;
	logic [ANGLE_W-1:0] pos_q;

	// Transform datapath
	logic signed [15:0] ia_q, ib_q, ic_q;
	logic signed [15:0] sn_q, cs_q;
	logic signed [15:0] beta_q, id_q;
	logic signed [31:0] acc_q;

	// Output register
	logic               out_valid_q;
	logic signed [15:0] out_a_q, out_b_q, out_c_q, out_beta_q, out_d_q, out_q_q;

	// Shared multiplier
	logic signed [17:0] mul_a;
	logic signed [15:0] mul_b;
	logic signed [33:0] mul_p;
	logic [31:0]        mul_lo;

	// Control
	logic               in_ready;
	logic               out_free;
	logic               out_load;

	// Combinational helpers
	logic [ANGLE_W-1:0] angle_red;
	logic [ANGLE_W:0]   cpos_sum;
	logic [ANGLE_W-1:0] cpos;
	logic signed [15:0] offset_sel;
	logic signed [15:0] cur_new;
	logic [31:0]        dsum;
	logic [31:0]        qsum;

	assign out_free = !out_valid_q || result.ready;

	// Next state and multiplier operands
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		out_load = 1'b0;
		mul_a    = 18'(med_q);
		mul_b    = scale_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (phase_item.valid) state_d = ST_SCALE;
			end
			ST_SCALE: begin
				state_d = (phase_q == PHASE_C) ? ST_REBUILD : ST_IDLE;
			end
			ST_REBUILD: begin
				state_d = ST_BETA;
			end
			ST_BETA: begin
				mul_a   = 18'(ia_q) + (18'(ib_q) <<< 1);
				mul_b   = INV_SQRT3_Q15;
				state_d = ST_D_FIRST;
			end
			ST_D_FIRST: begin
				mul_a   = 18'(beta_q);
				mul_b   = sn_q;
				state_d = ST_D_SECOND;
			end
			ST_D_SECOND: begin
				mul_a   = 18'(ia_q);
				mul_b   = cs_q;
				state_d = ST_Q_FIRST;
			end
			ST_Q_FIRST: begin
				mul_a   = 18'(beta_q);
				mul_b   = cs_q;
				state_d = ST_Q_SECOND;
			end
			ST_Q_SECOND: begin
				mul_a = 18'(ia_q);
				mul_b = sn_q;
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign mul_p  = mul_a * mul_b;
	assign mul_lo = mul_p[31:0];

	// Angle reduction and cosine position
	assign angle_red = (phase_item.rotor_angle >= STEPS_A) ?
		(phase_item.rotor_angle - STEPS_A) : phase_item.rotor_angle;
	assign cpos_sum  = {1'b0, pos_q} + {1'b0, QTR_A};
	assign cpos      = (cpos_sum >= {1'b0, STEPS_A}) ?
		ANGLE_W'(cpos_sum - {1'b0, STEPS_A}) : cpos_sum[ANGLE_W-1:0];

	// Scaled current of the item under work
	always_comb begin
		case (phase_q)
			PHASE_A: offset_sel = offset_a_q;
			PHASE_B: offset_sel = offset_b_q;
			default: offset_sel = offset_c_q;
		endcase
	end
	assign cur_new = offset_sel - signed'(mul_lo[SCALE_SHIFT+15:SCALE_SHIFT]);

	assign dsum = acc_q + mul_lo;
	assign qsum = acc_q - mul_lo;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q    <= SCALE_RESET;
			offset_a_q <= '0;
			offset_b_q <= '0;
			offset_c_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CURRENT_SCALE: scale_q    <= cfg_data;
				REG_ZERO_OFFSET_A: offset_a_q <= cfg_data;
				REG_ZERO_OFFSET_B: offset_b_q <= cfg_data;
				REG_ZERO_OFFSET_C: offset_c_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Held a and b values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_ia_q <= '0;
			held_ib_q <= '0;
			held_da_q <= '0;
			held_db_q <= '0;
		end else if (state_q == ST_SCALE) begin
			if (phase_q == PHASE_A) begin
				held_ia_q <= cur_new;
				held_da_q <= duty_q;
			end
			if (phase_q == PHASE_B) begin
				held_ib_q <= cur_new;
				held_db_q <= duty_q;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (phase_item.valid) begin
					phase_q <= phase_t'(phase_item.phase_index);
					med_q   <= median3(phase_item.first_sample, phase_item.second_sample,
						phase_item.third_sample);
					duty_q  <= phase_item.duty_compare;
					pos_q   <= angle_red;
				end
			end
			ST_SCALE: begin
				ic_q <= cur_new;
				sn_q <= sine_lookup(pos_q);
			end
			ST_REBUILD: begin
				// rebuild the phase with the strictly largest duty, else c
				if (held_da_q > held_db_q && held_da_q > duty_q) begin
					ia_q <= 16'sd0 - held_ib_q - ic_q;
					ib_q <= held_ib_q;
				end else if (held_db_q > held_da_q && held_db_q > duty_q) begin
					ia_q <= held_ia_q;
					ib_q <= 16'sd0 - held_ia_q - ic_q;
				end else begin
					ia_q <= held_ia_q;
					ib_q <= held_ib_q;
					ic_q <= 16'sd0 - held_ia_q - held_ib_q;
				end
				cs_q <= sine_lookup(cpos);
			end
			ST_BETA: begin
				beta_q <= signed'(mul_lo[30:15]);
			end
			ST_D_FIRST: begin
				acc_q <= mul_lo;
			end
			ST_D_SECOND: begin
				id_q <= signed'(dsum[30:15]);
			end
			ST_Q_FIRST: begin
				acc_q <= mul_lo;
			end
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_a_q    <= ia_q;
			out_b_q    <= ib_q;
			out_c_q    <= ic_q;
			out_beta_q <= beta_q;
			out_d_q    <= id_q;
			out_q_q    <= signed'(qsum[30:15]);
		end
	end

	assign phase_item.ready         = in_ready;
	assign result.valid             = out_valid_q;
	assign result.current_a         = out_a_q;
	assign result.current_b         = out_b_q;
	assign result.current_c         = out_c_q;
	assign result.current_beta      = out_beta_q;
	assign result.current_direct    = out_d_q;
	assign result.current_quadrature = out_q_q;

endmodule

FILE: sim/phase_current_clarke_park_tb.sv
// Self-checking bench for the phase current Clarke/Park block: directed and random items.
module phase_current_clarke_park_tb;
	import cpc_pkg::*;

	localparam int  ANGLE_COUNT   = 1000;
	localparam int  COS_LEAD      = 250;
	localparam int  INV_SQRT3     = 18919;
	localparam real TWO_PI        = 6.283185307179586;
	localparam int  SETTLE_CYCLES = 12;
	localparam int  STALL_LIMIT   = 1000;
	localparam int  REPORT_LIMIT  = 10;

	// One phase item as driven on the input channel
	typedef struct {
		phase_t             phase;
		logic signed [12:0] first;
		logic signed [12:0] second;
		logic signed [12:0] third;
		logic [15:0]        duty;
		logic [9:0]         angle;
	} adc_item_t;

	// One transform result
	typedef struct packed {
		logic signed [15:0] a;
		logic signed [15:0] b;
		logic signed [15:0] c;
		logic signed [15:0] beta;
		logic signed [15:0] direct;
		logic signed [15:0] quad;
	} currents_t;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      cfg_we;
	cfg_reg_t  cfg_index;
	logic [15:0] cfg_data;

	cpc_item_if   item_ch ();
	cpc_result_if res_ch ();

	phase_current_clarke_park i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.phase_item (item_ch),
		.result     (res_ch)
	);

	// Bench copy of registers and held phase data
	logic signed [15:0] gain_q11;
	logic signed [15:0] off_a;
	logic signed [15:0] off_b;
	logic signed [15:0] off_c;
	logic signed [15:0] held_a;
	logic signed [15:0] held_b;
	logic [15:0]        held_duty_a;
	logic [15:0]        held_duty_b;
	int                 sine_q15 [ANGLE_COUNT];

	currents_t pending_currents [$];
	bit        gaps_on;
	bit        stalls_on;
	int        err_count = 0;
	int        idle_cycles = 0;

	// Clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int sine_q15_at(input int k);
		real s;
		s = $sin(TWO_PI * k / ANGLE_COUNT) * 32767.0;
		return (s < 0.0) ? -$rtoi(0.5 - s) : $rtoi(s + 0.5);
	endfunction

	// Median of the samples, scaled by the gain, taken from the phase offset
	function automatic logic signed [15:0] phase_current_q9(input adc_item_t it,
			input logic signed [15:0] offset);
		logic signed [12:0] lo;
		logic signed [12:0] hi;
		logic signed [12:0] mid;
		int                 prod;
		lo   = (it.first < it.second) ? it.first : it.second;
		hi   = (it.first < it.second) ? it.second : it.first;
		mid  = (it.third < hi) ? it.third : hi;
		mid  = (mid > lo) ? mid : lo;
		prod = int'(mid) * int'(gain_q11);
		return offset - prod[26:11];
	endfunction

	// Updates held data; a c item queues its expected currents
	function automatic void advance_phase_model(input adc_item_t it);
		logic signed [15:0] ia;
		logic signed [15:0] ib;
		logic signed [15:0] ic;
		logic signed [15:0] beta;
		currents_t          r;
		int                 weighted;
		int                 pos;
		int                 cpos;
		int                 sn;
		int                 cs;
		int                 d_acc;
		int                 q_acc;
		case (it.phase)
			PHASE_A: begin
				held_a      = phase_current_q9(it, off_a);
				held_duty_a = it.duty;
			end
			PHASE_B: begin
				held_b      = phase_current_q9(it, off_b);
				held_duty_b = it.duty;
			end
			PHASE_C: begin
				ia = held_a;
				ib = held_b;
				ic = phase_current_q9(it, off_c);
				// strictly largest duty gets rebuilt, c when there is no strict maximum
				if (held_duty_a > held_duty_b && held_duty_a > it.duty) begin
					ia = -(ib + ic);
				end else if (held_duty_b > held_duty_a && held_duty_b > it.duty) begin
					ib = -(ia + ic);
				end else begin
					ic = -(ia + ib);
				end
				weighted = (int'(ia) + 2 * int'(ib)) * INV_SQRT3;
				beta     = weighted[30:15];
				pos      = int'(it.angle) % ANGLE_COUNT;
				cpos     = (pos + COS_LEAD) % ANGLE_COUNT;
				sn       = sine_q15[pos];
				cs       = sine_q15[cpos];
				d_acc    = int'(beta) * sn + int'(ia) * cs;
				q_acc    = int'(beta) * cs - int'(ia) * sn;
				r        = {ia, ib, ic, beta, d_acc[30:15], q_acc[30:15]};
				pending_currents.push_back(r);
			end
			default: begin
				// phase index three is dropped
			end
		endcase
	endfunction

	function automatic adc_item_t mk_item(input phase_t ph, input int s0, input int s1,
			input int s2, input int duty, input int angle);
		adc_item_t it;
		it.phase  = ph;
		it.first  = 13'(s0);
		it.second = 13'(s1);
		it.third  = 13'(s2);
		it.duty   = 16'(duty);
		it.angle  = 10'(angle);
		return it;
	endfunction

	// Duties lean toward a few values so that ties come up often
	function automatic logic [15:0] rand_duty();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic adc_item_t rand_item(input phase_t ph);
		adc_item_t it;
		it.phase  = ph;
		it.first  = 13'($urandom);
		it.second = ($urandom_range(0, 7) == 0) ? it.first : 13'($urandom);
		it.third  = ($urandom_range(0, 7) == 0) ? it.second : 13'($urandom);
		it.duty   = rand_duty();
		it.angle  = 10'($urandom);
		return it;
	endfunction

	// Sends one item, predicts on acceptance
	task automatic send_item(input adc_item_t it);
		int gap;
		gap = gaps_on ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid         <= 1'b1;
		item_ch.phase_index   <= it.phase;
		item_ch.first_sample  <= it.first;
		item_ch.second_sample <= it.second;
		item_ch.third_sample  <= it.third;
		item_ch.duty_compare  <= it.duty;
		item_ch.rotor_angle   <= it.angle;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		advance_phase_model(it);
	endtask

	// Holds the input off until every queued result is out and the block settles
	task automatic wait_results_drained();
		item_ch.valid <= 1'b0;
		while (pending_currents.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input cfg_reg_t idx, input logic [15:0] value);
		cfg_index <= idx;
		cfg_data  <= value;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_CURRENT_SCALE: gain_q11 = value;
			REG_ZERO_OFFSET_A: off_a    = value;
			REG_ZERO_OFFSET_B: off_b    = value;
			REG_ZERO_OFFSET_C: off_c    = value;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic load_registers(input logic [15:0] scale, input logic [15:0] oa,
			input logic [15:0] ob, input logic [15:0] oc);
		wait_results_drained();
		write_register(REG_CURRENT_SCALE, scale);
		write_register(REG_ZERO_OFFSET_A, oa);
		write_register(REG_ZERO_OFFSET_B, ob);
		write_register(REG_ZERO_OFFSET_C, oc);
	endtask

	// Mostly complete a/b/c frames, some stray and broken ones
	task automatic send_traffic(input int n_items);
		int sent;
		int pick;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 9);
			if (pick < 8) begin
				send_item(rand_item(PHASE_A));
				send_item(rand_item(PHASE_B));
				send_item(rand_item(PHASE_C));
				sent += 3;
			end else if (pick == 8) begin
				send_item(rand_item(phase_t'($urandom_range(0, 3))));
				sent += 1;
			end else begin
				send_item(rand_item(phase_t'($urandom_range(0, 2))));
				send_item(rand_item(PHASE_C));
				sent += 2;
			end
		end
	endtask

	// c items before any a or b item was seen
	task automatic test_unprimed_phase_c();
		send_item(mk_item(PHASE_C, 100, -50, 7, 0, 0));
		send_item(mk_item(PHASE_C, 4095, 4095, 4095, 65535, 1023));
	endtask

	// Sample, duty and angle extremes; each phase rebuilt once
	task automatic test_field_extremes();
		send_item(mk_item(PHASE_A, -4096, -4096, -4096, 0, 0));
		send_item(mk_item(PHASE_B, 4095, 4095, 4095, 65535, 0));
		send_item(mk_item(PHASE_C, -4096, 4095, 0, 1, 0));
		send_item(mk_item(PHASE_A, 4095, -4096, 4095, 65535, 0));
		send_item(mk_item(PHASE_B, 0, 0, 0, 0, 0));
		send_item(mk_item(PHASE_C, -4096, -4096, 4095, 0, 999));
		send_item(mk_item(PHASE_A, -1, 1, 0, 65535, 1023));
		send_item(mk_item(PHASE_B, 4095, -4096, -4096, 65535, 1023));
		send_item(mk_item(PHASE_C, 2047, -2048, 4095, 65535, 1000));
	endtask

	// Median from three rotations of the sample order, and with tied samples
	task automatic test_median_orders();
		send_item(mk_item(PHASE_A, 1, 2, 3, 10, 0));
		send_item(mk_item(PHASE_B, 3, 1, 2, 20, 0));
		send_item(mk_item(PHASE_C, 2, 3, 1, 5, 250));
		send_item(mk_item(PHASE_A, -7, -7, 9, 300, 0));
		send_item(mk_item(PHASE_B, 9, -7, 9, 300, 0));
		send_item(mk_item(PHASE_C, 5, 5, 5, 299, 750));
	endtask

	// Phase index three before and between the phases of a frame
	task automatic test_ignored_phase();
		send_item(mk_item(PHASE_NONE, -4096, 4095, 0, 65535, 1023));
		send_item(mk_item(PHASE_A, 1000, 1200, 900, 400, 0));
		send_item(mk_item(PHASE_NONE, 4095, -4096, -1, 0, 0));
		send_item(mk_item(PHASE_B, -800, -900, -700, 100, 0));
		send_item(mk_item(PHASE_C, 300, 200, 100, 200, 500));
	endtask

	// Repeated and missing phases reuse the latest held values
	task automatic test_out_of_order();
		send_item(mk_item(PHASE_C, -300, 20, 40, 0, 123));
		send_item(mk_item(PHASE_B, 50, 60, 70, 65535, 0));
		send_item(mk_item(PHASE_C, 11, 22, 33, 7, 1010));
	endtask

	// Register extremes, each with a batch of frames
	task automatic test_register_extremes();
		load_registers(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_traffic(45);
		load_registers(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_traffic(45);
		load_registers(16'h0000, 16'($urandom), 16'($urandom), 16'($urandom));
		send_traffic(45);
		load_registers(16'h0001, 16'h0000, 16'h0000, 16'h0000);
		send_traffic(45);
		load_registers(16'hFFFF, 16'($urandom), 16'($urandom), 16'($urandom));
		send_traffic(45);
		load_registers(16'd2048, 16'($urandom), 16'($urandom), 16'($urandom));
		send_traffic(45);
	endtask

	// Random registers and idle patterns per round
	task automatic test_random_traffic();
		for (int round = 0; round < 10; round++) begin
			load_registers(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
			gaps_on   = (round % 4) < 2;
			stalls_on = (round % 4) == 0 || (round % 4) == 2;
			send_traffic(80);
		end
	endtask

	// Result sink with random stalls
	initial begin : result_sink
		int stall;
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = stalls_on ? $urandom_range(0, 4) : 0;
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (res_ch.valid !== 1'b1);
		end
	end

	// Result check against the oldest expectation
	always @(posedge clk) begin
		currents_t got;
		currents_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = {res_ch.current_a, res_ch.current_b, res_ch.current_c,
				res_ch.current_beta, res_ch.current_direct, res_ch.current_quadrature};
			if (pending_currents.size() == 0) begin
				if (err_count < REPORT_LIMIT) begin
					$display("unexpected result: a=%0d b=%0d c=%0d beta=%0d d=%0d q=%0d",
						got.a, got.b, got.c, got.beta, got.direct, got.quad);
				end
				err_count = err_count + 1;
			end else begin
				want = pending_currents.pop_front();
				if (got.a !== want.a || got.b !== want.b || got.c !== want.c ||
						got.beta !== want.beta || got.direct !== want.direct ||
						got.quad !== want.quad) begin
					if (err_count < REPORT_LIMIT) begin
						$display("mismatch: expected a=%0d b=%0d c=%0d beta=%0d d=%0d q=%0d",
							want.a, want.b, want.c, want.beta, want.direct, want.quad);
						$display("          actual   a=%0d b=%0d c=%0d beta=%0d d=%0d q=%0d",
							got.a, got.b, got.c, got.beta, got.direct, got.quad);
					end
					err_count = err_count + 1;
				end
			end
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Test sequence
	initial begin
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_index             = REG_CURRENT_SCALE;
		cfg_data              = '0;
		item_ch.valid         = 1'b0;
		item_ch.phase_index   = PHASE_A;
		item_ch.first_sample  = '0;
		item_ch.second_sample = '0;
		item_ch.third_sample  = '0;
		item_ch.duty_compare  = '0;
		item_ch.rotor_angle   = '0;
		gain_q11              = 16'sd2048;
		off_a                 = '0;
		off_b                 = '0;
		off_c                 = '0;
		held_a                = '0;
		held_b                = '0;
		held_duty_a           = '0;
		held_duty_b           = '0;
		gaps_on               = 1'b1;
		stalls_on             = 1'b1;
		for (int k = 0; k < ANGLE_COUNT; k++) begin
			sine_q15[k] = sine_q15_at(k);
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unprimed_phase_c();
		test_field_extremes();
		test_median_orders();
		test_ignored_phase();
		test_out_of_order();
		test_register_extremes();
		test_random_traffic();

		gaps_on   = 1'b1;
		stalls_on = 1'b1;
		wait_results_drained();
		if (err_count == 0 && pending_currents.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
